// File: hw/rtl/tdf_pkg.sv
// Shared constants for the trial-division factoriser.
package tdf_pkg;

  localparam int unsigned VALUE_BITS     = 32;
  localparam int unsigned MAX_VALUE_BITS = 64;
  localparam int unsigned FIELD_BITS     = 32;
  localparam int unsigned FIRST_DIVISOR  = 2;

endpackage

// File: hw/rtl/tdf_in_if.sv
// Input channel: one number to factor per transaction.
interface tdf_in_if;

  logic                             valid;
  logic                             ready;
  logic [tdf_pkg::FIELD_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);

endinterface

// File: hw/rtl/tdf_out_if.sv
// Output channel: one prime factor per transaction.
interface tdf_out_if;

  logic                             valid;
  logic                             ready;
  logic [tdf_pkg::FIELD_BITS-1:0] factor;
  logic                             last;
  logic                             too_small;

  modport source (output valid, output factor, output last, output too_small, input ready);
  modport sink   (input valid, input factor, input last, input too_small, output ready);

endinterface

// File: hw/rtl/tdf_div.sv
// Bit-serial restoring divider shared by every trial of the factoriser.
module tdf_div #(
  parameter int unsigned ValueBits = tdf_pkg::VALUE_BITS,
  parameter int unsigned DivBits   = (ValueBits + 1) / 2 + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ValueBits-1:0] dividend_i,
  input  logic [DivBits-1:0]   divisor_i,
  output logic                 done_o,
  output logic [ValueBits-1:0] quotient_o,
  output logic [DivBits-1:0]   remainder_o
);

  localparam int unsigned CntBits = $clog2(ValueBits + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [ValueBits-1:0] quo_q, quo_d;
  logic [DivBits-1:0]   rem_q, rem_d;
  logic [DivBits-1:0]   dsr_q, dsr_d;
  logic [DivBits:0]     shifted;
  logic                 fits;

  assign shifted = {rem_q, quo_q[ValueBits-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(ValueBits);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[ValueBits-2:0], fits};
      rem_d = fits ? DivBits'(shifted - {1'b0, dsr_q}) : DivBits'(shifted);
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: hw/rtl/trial_division_factorizer_core.sv
// Top level of the trial-division factoriser: sequencer, divider and result register.
// Accepts one number, then emits its prime factors in ascending order, repeats
// included, one transaction each, the final one flagged with last; a number below 2
// yields a single transaction with too_small set and factor 0. Each trial division
// costs one pass of the bit-serial divider, so a divisor that divides k times costs
// at most k + 1 passes; each emitted factor adds a stay in the push state, longer
// while the output is stalled. The divider gives quotient and remainder together, so
// one pass settles both the divisibility test and the square-root bound.
// The input is ready again once the final transaction has entered the output register.
module trial_division_factorizer_core #(
  parameter int unsigned ValueBits = tdf_pkg::VALUE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tdf_in_if.sink           in_i,
  tdf_out_if.source        out_o
);

  localparam int unsigned DivBits   = (ValueBits + 1) / 2 + 1;
  localparam int unsigned WideBits  = tdf_pkg::MAX_VALUE_BITS;
  localparam int unsigned FieldBits = tdf_pkg::FIELD_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } state_e;

  state_e               state_q, state_d;
  logic [ValueBits-1:0] rem_q, rem_d;
  logic [DivBits-1:0]   dvs_q, dvs_d;
  logic [ValueBits-1:0] pend_factor_q, pend_factor_d;
  logic                 pend_last_q, pend_last_d;
  logic                 pend_small_q, pend_small_d;
  logic                 out_valid_q, out_valid_d;
  logic [FieldBits-1:0] out_factor_q;
  logic                 out_last_q;
  logic                 out_small_q;
  logic [ValueBits-1:0] in_value;
  logic [WideBits-1:0]  pend_wide;
  logic                 div_start;
  logic                 div_done;
  logic [ValueBits-1:0] div_quo;
  logic [DivBits-1:0]   div_rem;
  logic                 out_load;

  assign in_value  = ValueBits'(in_i.value);
  assign pend_wide = WideBits'(pend_factor_q);
  assign out_load  = (state_q == S_PUSH) && (!out_valid_q || out_o.ready);

  tdf_div #(
    .ValueBits (ValueBits),
    .DivBits   (DivBits)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (rem_d),
    .divisor_i   (dvs_d),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d       = state_q;
    rem_d         = rem_q;
    dvs_d         = dvs_q;
    pend_factor_d = pend_factor_q;
    pend_last_d   = pend_last_q;
    pend_small_d  = pend_small_q;
    div_start     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_value < ValueBits'(tdf_pkg::FIRST_DIVISOR)) begin
            pend_factor_d = '0;
            pend_last_d   = 1'b1;
            pend_small_d  = 1'b1;
            state_d       = S_PUSH;
          end else begin
            rem_d     = in_value;
            dvs_d     = DivBits'(tdf_pkg::FIRST_DIVISOR);
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          pend_small_d = 1'b0;
          if (ValueBits'(dvs_q) > div_quo) begin
            // bound passed: what is left is prime
            pend_factor_d = rem_q;
            pend_last_d   = 1'b1;
            state_d       = S_PUSH;
          end else if (div_rem == '0) begin
            pend_factor_d = ValueBits'(dvs_q);
            pend_last_d   = 1'b0;
            rem_d         = div_quo;
            state_d       = S_PUSH;
          end else begin
            dvs_d     = dvs_q + DivBits'(1);
            div_start = 1'b1;
          end
        end
      end
      S_PUSH: begin
        if (out_load) begin
          if (pend_last_q) begin
            state_d = S_IDLE;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q         <= rem_d;
    dvs_q         <= dvs_d;
    pend_factor_q <= pend_factor_d;
    pend_last_q   <= pend_last_d;
    pend_small_q  <= pend_small_d;
    if (out_load) begin
      out_factor_q <= pend_wide[FieldBits-1:0];
      out_last_q   <= pend_last_q;
      out_small_q  <= pend_small_q;
    end
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.factor    = out_factor_q;
  assign out_o.last      = out_last_q;
  assign out_o.too_small = out_small_q;

endmodule

// File: hw/rtl/tdf_checker.sv
// Port-level checks for the factoriser and their bind to the top level.
module tdf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [tdf_pkg::FIELD_BITS-1:0] factor_i,
  input logic                             last_i,
  input logic                             too_small_i
);

  localparam int unsigned FieldBits = tdf_pkg::FIELD_BITS;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input still ready after a transaction");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && too_small_i) |-> (last_i && factor_i == '0))
    else $error("too_small result not final or non-zero");

  a_factor_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !too_small_i) |-> (factor_i >= FieldBits'(tdf_pkg::FIRST_DIVISOR)))
    else $error("factor below two");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(factor_i) && $stable(last_i)))
    else $error("stalled result changed");

endmodule

bind trial_division_factorizer_core tdf_checker u_tdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .factor_i    (out_o.factor),
  .last_i      (out_o.last),
  .too_small_i (out_o.too_small)
);

// File: bench/tb.sv
// Testbench for trial_division_factorizer_core: predicted prime factors checked per transaction.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxFactors = 32;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned DrainCycles = 64;

  typedef struct packed {
    logic [tdf_pkg::FIELD_BITS-1:0] factor;
    logic                           last;
    logic                           too_small;
  } factor_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tdf_in_if  in_ch ();
  tdf_out_if out_ch ();

  trial_division_factorizer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #2 clk_i = ~clk_i;

  logic [tdf_pkg::VALUE_BITS-1:0] pending_values[$];
  factor_t                        expected_factors[$];
  bit                             driving = 1'b0;
  bit                             no_idle = 1'b0;
  bit                             long_hold_req = 1'b0;
  int unsigned                    mismatches = 0;

  // Factorises one accepted number and queues the transactions it must produce.
  function automatic void predict_factors(input logic [tdf_pkg::VALUE_BITS-1:0] v);
    longint unsigned rem;
    longint unsigned div;
    int unsigned     n;
    factor_t         r;
    if (v < tdf_pkg::FIRST_DIVISOR) begin
      r.factor = '0;
      r.last = 1'b1;
      r.too_small = 1'b1;
      expected_factors.push_back(r);
      return;
    end
    rem = 64'(v);
    div = 64'(tdf_pkg::FIRST_DIVISOR);
    n = 0;
    r.last = 1'b0;
    r.too_small = 1'b0;
    while (div <= rem / div) begin
      while (rem % div == 0) begin
        if (n < MaxFactors) begin
          r.factor = div[tdf_pkg::FIELD_BITS-1:0];
          expected_factors.push_back(r);
          n++;
        end
        rem = rem / div;
      end
      div++;
    end
    if (rem > 1 && n < MaxFactors) begin
      r.factor = rem[tdf_pkg::FIELD_BITS-1:0];
      expected_factors.push_back(r);
    end
    expected_factors[expected_factors.size()-1].last = 1'b1;
  endfunction

  // Product of small random multipliers, sometimes with a moderate cofactor on top.
  function automatic logic [tdf_pkg::VALUE_BITS-1:0] smooth_value();
    longint unsigned v;
    longint unsigned m;
    longint unsigned bound;
    int unsigned     misses;
    v = 1;
    misses = 0;
    while (misses < 4) begin
      m = $urandom_range(2, 1 << $urandom_range(1, 8));
      if (v * m <= 64'hFFFF_FFFF) v = v * m;
      else misses++;
    end
    bound = 64'hFFFF_FFFF / v;
    if (bound > (1 << 18)) bound = 1 << 18;
    if (bound >= 2 && $urandom_range(0, 1)) v = v * $urandom_range(2, bound);
    return v[tdf_pkg::VALUE_BITS-1:0];
  endfunction

  task automatic send_value(input logic [tdf_pkg::VALUE_BITS-1:0] v);
    pending_values.push_back(v);
  endtask

  task automatic wait_idle();
    while (pending_values.size() != 0 || driving || expected_factors.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Input driver
  initial begin
    logic [tdf_pkg::VALUE_BITS-1:0] v;
    int unsigned                    gap;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    @(posedge rst_ni);
    forever begin
      if (pending_values.size() == 0) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end else begin
        v = pending_values.pop_front();
        driving = 1'b1;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge clk_i); while (!in_ch.ready);
        predict_factors(v);
        driving = 1'b0;
      end
    end
  end

  // Output receiver; a long hold-off is taken when requested
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (long_hold_req) begin
        stall = LongHoldCycles;
        long_hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    factor_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_factors.size() == 0) begin
        $display("%0t: unexpected transaction factor=%0d last=%0b too_small=%0b",
                 $time, out_ch.factor, out_ch.last, out_ch.too_small);
        mismatches++;
      end else begin
        exp_r = expected_factors.pop_front();
        if (out_ch.factor !== exp_r.factor) begin
          $display("%0t: factor expected %0d actual %0d", $time, exp_r.factor, out_ch.factor);
          mismatches++;
        end
        if (out_ch.last !== exp_r.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_r.last, out_ch.last);
          mismatches++;
        end
        if (out_ch.too_small !== exp_r.too_small) begin
          $display("%0t: too_small expected %0b actual %0b",
                   $time, exp_r.too_small, out_ch.too_small);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'd3);
    send_value(32'd4);
    send_value(32'd21);
    send_value(32'd49);
    send_value(32'd169);
    send_value(32'd65521);
    send_value(32'd1000003);
    send_value(32'd223092870);
    send_value(32'd3486784401);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'hFFFF_0000);
    send_value(32'h5555_5555);
    send_value(32'hAAAA_AAAA);
    send_value(32'h0000_FFFF);
    wait_idle();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (20) send_value($urandom_range(0, 4096));
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    int unsigned pick;
    repeat (56) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) send_value($urandom_range(0, 3));
      else if (pick == 1) send_value($urandom_range(0, 1 << 20));
      else send_value(smooth_value());
    end
    wait_idle();
  endtask

  // Receiver holds off while numbers with many factors keep arriving
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    send_value(32'h8000_0000);
    send_value(32'd3486784401);
    send_value(32'd223092870);
    send_value(32'h4000_0000);
    send_value(32'd0);
    send_value(32'd720720);
    wait_idle();
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_back_to_back();
    test_random();
    test_backpressure();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
